@@ hw/rtl/rdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, sizes and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_RADIX   = 32;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 5;
    localparam int CHAR_BITS   = 7;
    // Base 2 needs one digit per value bit, so that many cells.
    localparam int NUM_CELLS   = VALUE_BITS;
    // The last cell sees its final bit once the carry has passed the register of every cell below it.
    localparam int CONV_CYCLES = VALUE_BITS + NUM_CELLS - 1;
    localparam int CYC_W       = $clog2(CONV_CYCLES);
    localparam int CNT_W       = $clog2(NUM_CELLS + 1);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'h41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DIGIT_BITS'(10)) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        else begin
            c = CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(10);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/rdc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_cell
// One digit cell: doubles its digit, adds the carry from below, reduces by
// the base and passes the overflow carry up through a register.
// ----------------------------------------------------------------------------
module rdc_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rdc_pkg::cell_ctrl_t                  ctrl,
    input  logic [rdc_pkg::RADIX_BITS-1:0]       radix,
    input  logic                                 cin_vld,
    input  logic                                 cin_bit,
    input  logic [rdc_pkg::DIGIT_BITS-1:0]       digit_in,
    output logic                                 cout_vld,
    output logic                                 cout_bit,
    output logic [rdc_pkg::DIGIT_BITS-1:0]       digit
);
    import rdc_pkg::*;

    logic [DIGIT_BITS-1:0] digit_reg, digit_next;
    logic                  vld_reg, vld_next;
    logic                  bit_reg, bit_next;
    logic [RADIX_BITS-1:0] sum;
    logic                  over;

    // The digit stays below the base, so one subtraction is enough.
    assign sum  = {digit_reg, cin_bit};
    assign over = (sum >= radix);

    always_comb
    begin
        digit_next = digit_reg;
        vld_next   = 1'b0;
        bit_next   = 1'b0;
        if (ctrl.clear) begin
            digit_next = '0;
        end
        else if (ctrl.shift) begin
            digit_next = digit_in;
        end
        else if (cin_vld) begin
            vld_next = 1'b1;
            bit_next = over;
            if (over) begin
                digit_next = DIGIT_BITS'(sum - radix);
            end
            else begin
                digit_next = DIGIT_BITS'(sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        bit_reg   <= bit_next;
    end

    assign cout_vld = vld_reg;
    assign cout_bit = bit_reg;
    assign digit    = digit_reg;

endmodule

@@ hw/rtl/rdc_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_chain
// Row of digit cells, least significant digit at cell zero. During output
// the digits shift up toward the top cell, which is read out.
// ----------------------------------------------------------------------------
module rdc_chain (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rdc_pkg::cell_ctrl_t                  ctrl,
    input  logic [rdc_pkg::RADIX_BITS-1:0]       radix,
    input  logic                                 feed_vld,
    input  logic                                 feed_bit,
    output logic [rdc_pkg::DIGIT_BITS-1:0]       top_digit
);
    import rdc_pkg::*;

    logic                  vld   [NUM_CELLS+1];
    logic                  cbit  [NUM_CELLS+1];
    logic [DIGIT_BITS-1:0] dig   [NUM_CELLS+1];

    assign vld[0]  = feed_vld;
    assign cbit[0] = feed_bit;
    assign dig[0]  = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        rdc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .radix    (radix),
            .cin_vld  (vld[i]),
            .cin_bit  (cbit[i]),
            .digit_in (dig[i]),
            .cout_vld (vld[i+1]),
            .cout_bit (cbit[i+1]),
            .digit    (dig[i+1])
        );
    end

    // The top cell's carry never overflows for a valid base and is unused.
    assign top_digit = dig[NUM_CELLS];

endmodule

@@ hw/rtl/radix_digit_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts a 31-bit unsigned value to ASCII digits in base 2 to 32.
// ----------------------------------------------------------------------------
// One item in gives one result item per digit, most significant digit first,
// with is_last set on the least significant one. Digits 0-9 become '0'-'9'
// and 10-31 become 'A'-'V'; a value of zero gives the single digit '0'. A
// base below 2 or above 32 gives one result with empty_res and is_last set
// and digit_char zero. Conversion runs in a row of 31 digit cells: the value
// enters bit by bit, most significant first, and each cell doubles its digit,
// adds the carry from the cell below and reduces by the base, handing its own
// carry upward through a register. Once the carry wave has passed the whole
// row, the digits shift up out of the top cell, one per cycle while the
// output register is free or being read, leading zeros being dropped. One
// item is in work at a time; a new item is taken once the last result has
// moved into the output register and that register is free or being read.
// ----------------------------------------------------------------------------
module radix_digit_converter_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rdc_pkg::VALUE_BITS-1:0]       value,
    input  logic [rdc_pkg::RADIX_BITS-1:0]       radix,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [rdc_pkg::CHAR_BITS-1:0]        digit_char,
    output logic                                 is_last,
    output logic                                 empty_res
);
    import rdc_pkg::*;

    state_t                state_reg, state_next;
    logic [CYC_W-1:0]      cyc_reg, cyc_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  started_reg, started_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [RADIX_BITS-1:0] radix_reg, radix_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_BITS-1:0]  char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  empty_reg, empty_next;

    cell_ctrl_t            ctrl;
    logic                  feed_vld;
    logic [DIGIT_BITS-1:0] top_digit;
    logic                  slot_free;
    logic                  accept;
    logic                  radix_ok;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign radix_ok  = (radix >= RADIX_BITS'(2)) && (radix <= RADIX_BITS'(MAX_RADIX));
    assign feed_vld  = (state_reg == ST_CONV) && (cyc_reg < CYC_W'(VALUE_BITS));

    always_comb
    begin
        state_next     = state_reg;
        cyc_next       = cyc_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        value_next     = value_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ctrl.clear     = 1'b0;
        ctrl.shift     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (radix_ok) begin
                        ctrl.clear   = 1'b1;
                        value_next   = value;
                        radix_next   = radix;
                        cyc_next     = '0;
                        rem_next     = CNT_W'(NUM_CELLS);
                        started_next = 1'b0;
                        state_next   = ST_CONV;
                    end
                    else begin
                        out_valid_next = 1'b1;
                        char_next      = '0;
                        last_next      = 1'b1;
                        empty_next     = 1'b1;
                    end
                end
            end
            ST_CONV:
            begin
                value_next = {value_reg[VALUE_BITS-2:0], 1'b0};
                cyc_next   = cyc_reg + CYC_W'(1);
                if (cyc_reg == CYC_W'(CONV_CYCLES - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Leading zeros are dropped, but the lowest digit always goes out.
                if (!started_reg && (top_digit == '0) && (rem_reg != CNT_W'(1))) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - CNT_W'(1);
                end
                else if (slot_free) begin
                    ctrl.shift     = 1'b1;
                    rem_next       = rem_reg - CNT_W'(1);
                    started_next   = 1'b1;
                    out_valid_next = 1'b1;
                    char_next      = digit_to_ascii(top_digit);
                    last_next      = (rem_reg == CNT_W'(1));
                    empty_next     = 1'b0;
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cyc_reg       <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cyc_reg       <= cyc_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    rdc_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .radix     (radix_reg),
        .feed_vld  (feed_vld),
        .feed_bit  (value_reg[VALUE_BITS-1]),
        .top_digit (top_digit)
    );

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign is_last    = last_reg;
    assign empty_res  = empty_reg;

endmodule

@@ dv/radix_digit_converter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_top_tb
// Self-checking testbench of the radix digit converter.
// ----------------------------------------------------------------------------
// Conversion requests (value and base) wait in a queue that the stimulus
// process fills phase by phase. A clocked driver hands them to the block over
// a valid/ready channel. Each accepted item is converted here as well, and the
// digits it should give are stored in order. A clocked monitor takes every
// result item and compares it, field by field, with the oldest stored digit.
// The phases vary how often the sender idles and the receiver stalls, and one
// phase holds the receiver off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module radix_digit_converter_top_tb;

    import rdc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_ITEMS  = 60;
    localparam int MAX_REPORTS  = 10;
    // Slowest correct run: about 270 items of up to 31 digits, each digit
    // waiting out receiver stalls, plus the conversion time of each item.
    // Taken several times over.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 2 * (CONV_CYCLES + NUM_CELLS);

    // One conversion request: the value and the base it is to be shown in.
    typedef struct {
        logic [VALUE_BITS-1:0] val;
        logic [RADIX_BITS-1:0] base;
    } request_t;

    // One digit as the block should present it.
    typedef struct packed {
        logic [CHAR_BITS-1:0] ch;
        logic                 last;
        logic                 empty;
    } digit_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [VALUE_BITS-1:0] value      = '0;
    logic [RADIX_BITS-1:0] radix      = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [CHAR_BITS-1:0]  digit_char;
    logic                  is_last;
    logic                  empty_res;

    request_t conv_requests[$];
    digit_t   pending_digits[$];

    // Idling knobs, in percent, and the long receiver hold-off.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_go    = 1'b0;
    logic hold_done;
    int   hold_cnt;

    int n_items    = 0;
    int n_digits   = 0;
    int n_invalid  = 0;
    int max_len    = 0;
    int n_errors   = 0;
    int cycle_cnt  = 0;

    radix_digit_converter_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .is_last    (is_last),
        .empty_res  (empty_res)
    );

    always #(CLK_HALF) clk = ~clk;

    // Converts one value to its digits by repeated division and appends them,
    // most significant first, to the digits still awaited from the block.
    function automatic void convert_to_digits(input logic [VALUE_BITS-1:0] v,
                                              input logic [RADIX_BITS-1:0] b);
        logic [DIGIT_BITS-1:0] rems[NUM_CELLS];
        logic [VALUE_BITS-1:0] w;
        logic [DIGIT_BITS-1:0] d;
        digit_t                dg;
        int                    cnt;
        w   = v;
        cnt = 0;
        // A base outside 2 to MAX_RADIX yields a single empty marker.
        if (b < 2 || b > MAX_RADIX) begin
            dg.ch    = '0;
            dg.last  = 1'b1;
            dg.empty = 1'b1;
            pending_digits.push_back(dg);
            n_invalid++;
            return;
        end
        // A zero value still produces one digit, since the loop runs once.
        do begin
            rems[cnt] = DIGIT_BITS'(w % b);
            cnt++;
            w = w / b;
        end while (w != 0 && cnt < NUM_CELLS);
        for (int k = cnt - 1; k >= 0; k--) begin
            d = rems[k];
            if (d < 10) begin
                dg.ch = CHAR_ZERO + CHAR_BITS'(d);
            end
            else begin
                dg.ch = CHAR_A + CHAR_BITS'(d - 10);
            end
            dg.last  = (k == 0);
            dg.empty = 1'b0;
            pending_digits.push_back(dg);
        end
        if (cnt > max_len) begin
            max_len = cnt;
        end
    endfunction

    task automatic queue_request(input logic [VALUE_BITS-1:0] v,
                                 input logic [RADIX_BITS-1:0] b);
        request_t r;
        r.val  = v;
        r.base = b;
        conv_requests.push_back(r);
    endtask

    // Mostly valid bases with values of every magnitude, so that every digit
    // count occurs; some bases are drawn from the whole field.
    task automatic queue_random(input int count);
        logic [VALUE_BITS-1:0] v;
        logic [RADIX_BITS-1:0] b;
        int                    pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                v = '0;
            end
            else if (pick < 10) begin
                v = '1;
            end
            else begin
                v = VALUE_BITS'($urandom() >> $urandom_range(31));
            end
            if ($urandom_range(99) < 85) begin
                b = RADIX_BITS'($urandom_range(MAX_RADIX, 2));
            end
            else begin
                b = RADIX_BITS'($urandom_range(63));
            end
            queue_request(v, b);
        end
    endtask

    // Waits until every request has gone in and every digit has come out.
    task automatic wait_idle();
        do begin
            @(negedge clk);
        end while (conv_requests.size() != 0 || in_valid || pending_digits.size() != 0);
    endtask

    // Driver: an item is taken when valid and ready are both high at an
    // edge. While valid is high, only then may the next request be offered or valid dropped.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            value    <= '0;
            radix    <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                convert_to_digits(value, radix);
                n_items++;
            end
            if (!in_valid || in_ready) begin
                if (conv_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    value    <= conv_requests[0].val;
                    radix    <= conv_requests[0].base;
                    void'(conv_requests.pop_front());
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted from the moment pressure is requested.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (pressure_go && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
            hold_cnt <= hold_cnt + 1;
        end
    end

    // Monitor: checks each taken result against the oldest awaited digit and
    // decides whether the receiver is ready in the next cycle.
    always @(posedge clk or negedge rst_n) begin
        digit_t exp_dg;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                n_digits++;
                if (pending_digits.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS) begin
                        $display("ERROR: unexpected result char=%h last=%b empty=%b",
                                 digit_char, is_last, empty_res);
                    end
                end
                else begin
                    exp_dg = pending_digits.pop_front();
                    if (digit_char !== exp_dg.ch || is_last !== exp_dg.last ||
                        empty_res !== exp_dg.empty) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("ERROR: result %0d expected char=%h last=%b empty=%b,",
                                     n_digits, exp_dg.ch, exp_dg.last, exp_dg.empty);
                            $display("       got char=%h last=%b empty=%b",
                                     digit_char, is_last, empty_res);
                        end
                    end
                end
            end
            if (pressure_go && !hold_done) begin
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("ERROR: run stopped after %0d cycles", CYCLE_LIMIT);
            $display("** radix_digit_converter_top: FAILED **");
            $finish;
        end
    end

    // Stimulus: reset, directed requests, the idling phases, then the backpressure phase.
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: zero, the largest value, the base extremes, the highest
        // digit letter, and bases just outside the valid range.
        queue_request('0, 2);
        queue_request('0, 10);
        queue_request('0, RADIX_BITS'(MAX_RADIX));
        queue_request('0, 0);
        queue_request('1, 2);
        queue_request('1, 3);
        queue_request('1, 10);
        queue_request('1, 16);
        queue_request('1, 31);
        queue_request('1, RADIX_BITS'(MAX_RADIX));
        queue_request('1, 63);
        queue_request(1, 2);
        queue_request(1, 1);
        queue_request(5, 0);
        queue_request(7, RADIX_BITS'(MAX_RADIX + 1));
        queue_request(31, RADIX_BITS'(MAX_RADIX));
        queue_request(1023, RADIX_BITS'(MAX_RADIX));
        queue_request(35, 36);
        queue_request(255, 16);
        queue_request(9, 10);
        queue_request(10, 11);
        queue_request(31'h2AAA_AAAA, 2);
        queue_request(31'h5555_5555, 4);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        // Backpressure: the receiver holds off while requests keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b1;
        queue_request('1, 2);
        queue_random(5);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_digits.size() != 0) begin
            n_errors += pending_digits.size();
            $display("ERROR: %0d expected results never arrived", pending_digits.size());
        end
        $display("Converted %0d values (%0d with an invalid base) into %0d result items.",
                 n_items, n_invalid, n_digits);
        $display("Longest digit string %0d; %0d mismatches.", max_len, n_errors);
        if (n_errors == 0) begin
            $display("** radix_digit_converter_top: PASSED **");
        end
        else begin
            $display("** radix_digit_converter_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_cell.sv
hw/rtl/rdc_chain.sv
hw/rtl/radix_digit_converter_top.sv
dv/radix_digit_converter_top_tb.sv
